FILE: rtl/core/ils_pkg.sv
// Shared constants, codes and word types for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int ACT_W       = 3;
    localparam int POS_W       = 8;
    localparam int VAL_W       = 32;
    localparam int CNTO_W      = 5;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // action codes on the request port
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_HEAD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INS_POS    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd4;

    // internal command codes after classification
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
    localparam logic [OP_W-1:0] OP_READ     = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    valid_res;
        logic                    ok;
        logic                    full_res;
        logic [CNTO_W-1:0]       entry_count;
    } rsp_t;

endpackage

FILE: rtl/core/ils_front.sv
// Front end: takes request words and classifies them into commands.
`timescale 1ns / 1ps

module ils_front (
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [ils_pkg::ACT_W-1:0]      action,
    input  logic [ils_pkg::POS_W-1:0]      position,
    input  logic signed [ils_pkg::VAL_W-1:0] value_in,
    output logic                           push_valid,
    input  logic                           push_ready,
    output ils_pkg::cmd_t                  push_cmd
);
    import ils_pkg::*;

    logic [OP_W-1:0] op;

    always_comb
    begin
        case (action)
            ACT_READ:     op = OP_READ;
            ACT_INS_HEAD: op = OP_INS_HEAD;
            ACT_INS_TAIL: op = OP_INS_TAIL;
            ACT_INS_POS:  op = OP_INS_POS;
            ACT_DELETE:   op = OP_DELETE;
            default:      op = OP_NONE;
        endcase
    end

    always_comb
    begin
        push_cmd.op    = op;
        // head insert is an insert at place 0; tail is resolved against the count later
        push_cmd.pos   = (op == OP_INS_HEAD) ? '0 : position;
        push_cmd.value = value_in;
    end

    assign push_valid = req_valid;
    assign req_ready  = push_ready;

endmodule

FILE: rtl/core/ils_cmd_queue.sv
// Short command queue between the front end and the entry cells.
`timescale 1ns / 1ps

module ils_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ils_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ils_pkg::cmd_t pop_cmd
);
    import ils_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("queue fill did not follow a push");

    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!do_push && !do_pop) |=> $stable(fill_reg) && $stable(rd_ptr_reg))
        else $error("queue moved without traffic");

endmodule

FILE: rtl/core/ils_back.sv
// Back end: shifting entry cells, entry count and the registered response word.
`timescale 1ns / 1ps

module ils_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  ils_pkg::cmd_t pop_cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ils_pkg::rsp_t rsp_word
);
    import ils_pkg::*;

    logic signed [VAL_W-1:0] cell_reg  [CAPACITY];
    logic signed [VAL_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic             do_pop;
    logic [CMP_W-1:0] pos_c, cnt_c, at_c;
    logic             is_ins, is_full, at_ok, pos_hit;
    logic             do_ins, do_del;

    assign pop_ready = !out_valid_reg || rsp_ready;
    assign do_pop    = pop_valid && pop_ready;

    assign pos_c   = CMP_W'(pop_cmd.pos);
    assign cnt_c   = CMP_W'(count_reg);
    assign pos_hit = pos_c < cnt_c;
    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign is_ins  = (pop_cmd.op == OP_INS_HEAD) || (pop_cmd.op == OP_INS_TAIL)
                  || (pop_cmd.op == OP_INS_POS);

    always_comb
    begin
        case (pop_cmd.op)
            OP_INS_TAIL: at_c = cnt_c;
            default:     at_c = pos_c;
        endcase
    end

    // place check comes before the capacity check
    assign at_ok  = at_c <= cnt_c;
    assign do_ins = do_pop && is_ins && at_ok && !is_full;
    assign do_del = do_pop && (pop_cmd.op == OP_DELETE) && pos_hit;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i > 0) ? i - 1 : 0;
        localparam int NEXT = (i < CAPACITY - 1) ? i + 1 : i;

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins)
            begin
                if (CMP_W'(i) == at_c)
                begin
                    cell_next[i] = pop_cmd.value;
                end
                else if (CMP_W'(i) > at_c)
                begin
                    cell_next[i] = cell_reg[PREV];
                end
            end
            else if (do_del && (CMP_W'(i) >= pos_c))
            begin
                cell_next[i] = cell_reg[NEXT];
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_del)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.entry_count = CNTO_W'(count_next);
        case (pop_cmd.op)
            OP_READ:
            begin
                if (pos_hit)
                begin
                    rsp_next.read_value = cell_reg[pop_cmd.pos[IDX_W-1:0]];
                    rsp_next.valid_res  = 1'b1;
                    rsp_next.ok         = 1'b1;
                end
                else
                begin
                    rsp_next.read_value = '1;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
            begin
                rsp_next.ok       = at_ok && !is_full;
                rsp_next.full_res = at_ok && is_full;
            end
            OP_DELETE:
            begin
                rsp_next.ok = pos_hit;
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (do_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ok_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rsp_reg.ok && rsp_reg.full_res))
        else $error("response both ok and full");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !do_pop |=> $stable(count_reg))
        else $error("count changed with no command");

    a_count_echo: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (rsp_reg.entry_count == CNTO_W'(count_reg)))
        else $error("response count differs from stored count");

endmodule

FILE: rtl/core/indexed_list_store_unit.sv
// Top level of the indexed list store: front end, command queue and entry cells.
`timescale 1ns / 1ps

// Holds an ordered list of up to CAPACITY signed 32-bit words and gives one
// response word per request (read, insert at head, tail or place, delete).
// Requests are decoded in the front end, pass through a two-deep command
// queue and are carried out by a row of entry cells that all shift in the
// same cycle; a steady stream of one request per cycle is sustained while
// the response side keeps up. The response word passes first through a queue
// slot and then through the output register, and is presented from there.
// The queue lets up to two requests be taken while a response waits.

module indexed_list_store_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [ils_pkg::ACT_W-1:0]        action,
    input  logic [ils_pkg::POS_W-1:0]        position,
    input  logic signed [ils_pkg::VAL_W-1:0] value_in,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic signed [ils_pkg::VAL_W-1:0] read_value,
    output logic                             valid_res,
    output logic                             ok,
    output logic                             full_res,
    output logic [ils_pkg::CNTO_W-1:0]       entry_count
);
    import ils_pkg::*;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;
    rsp_t rsp_word;

    ils_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .action     (action),
        .position   (position),
        .value_in   (value_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    ils_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ils_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    assign read_value  = rsp_word.read_value;
    assign valid_res   = rsp_word.valid_res;
    assign ok          = rsp_word.ok;
    assign full_res    = rsp_word.full_res;
    assign entry_count = rsp_word.entry_count;

endmodule
